// ----- sv/gsa_pkg.sv -----
package gsa_pkg;

    localparam int MAX_SLOTS_DEF     = 4096;
    localparam int INITIAL_SLOTS_DEF = 64;
    localparam int GEN_WIDTH_DEF     = 16;
    localparam int GROW_FLOOR        = 64;

    localparam logic [1:0] OP_ALLOC = 2'd0;
    localparam logic [1:0] OP_FREE  = 2'd1;
    localparam logic [1:0] OP_CHECK = 2'd2;

    localparam logic [1:0] STS_OK       = 2'd0;
    localparam logic [1:0] STS_FULL     = 2'd1;
    localparam logic [1:0] STS_IGNORED  = 2'd2;
    localparam logic [1:0] STS_OVERFLOW = 2'd3;

    typedef struct packed {
        logic [1:0]  operation;
        logic [11:0] slot_index;
        logic [15:0] handle_generation;
        logic        is_null;
    } t_in_item;

    typedef struct packed {
        logic [11:0] result_index;
        logic [15:0] result_generation;
        logic        handle_ok;
        logic [1:0]  status;
        logic [12:0] allocated_count;
    } t_out_item;

    typedef enum logic [2:0] {
        S_BOOT,
        S_IDLE,
        S_GROW,
        S_ISSUE,
        S_POP,
        S_FIN
    } t_state;

    typedef struct packed {
        logic accept;
        logic grow_start;
        logic grow_step;
        logic rd_stack;
        logic rd_gen_idx;
        logic rd_gen_slot;
        logic finish;
    } t_dp_cmd;

    typedef struct packed {
        logic fc_zero;
        logic cap_max;
        logic grow_done;
        logic out_free;
    } t_dp_stat;

endpackage

// ----- sv/generational_slot_allocator.sv -----
// Generational slot allocator.
// Input channel: i_in_valid / o_in_stall carry one transaction (allocate, free
// or check of a handle). Output channel: o_out_valid / i_out_stall carry one
// result per input transaction, in order.
// Free, check, full allocate and unused codes go from acceptance through S_FIN
// to the output register; a normal allocate passes S_POP first (stack read,
// then generation read, both through the registered memory ports).
// One transaction is in work at a time; the next is accepted the cycle after
// the result is loaded, so none is taken before the last one is through.
// An allocate that finds the stack empty first grows the table: one new slot
// is pushed per cycle, then the capacity is raised to the new value.
// After reset the block pushes its min(INITIAL_SLOTS, MAX_SLOTS) initial slots
// the same way, with o_in_stall high.
// The result sits in an output register; while the receiver stalls it holds,
// and a finished transaction waits in the block until the register frees.
module generational_slot_allocator #(
    parameter int MAX_SLOTS     = gsa_pkg::MAX_SLOTS_DEF,
    parameter int INITIAL_SLOTS = gsa_pkg::INITIAL_SLOTS_DEF,
    parameter int GEN_WIDTH     = gsa_pkg::GEN_WIDTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  gsa_pkg::t_in_item  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output gsa_pkg::t_out_item o_out_data
);
    import gsa_pkg::*;

    t_dp_cmd  cmd;
    t_dp_stat stat;

    gsa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_op       (i_in_data.operation),
        .i_stat     (stat),
        .o_cmd      (cmd),
        .o_in_stall (o_in_stall)
    );

    gsa_dp #(
        .MAX_SLOTS     (MAX_SLOTS),
        .INITIAL_SLOTS (INITIAL_SLOTS),
        .GEN_WIDTH     (GEN_WIDTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_in_data   (i_in_data),
        .i_out_stall (i_out_stall),
        .o_stat      (stat),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

endmodule

// ----- sv/gsa_ctrl.sv -----
module gsa_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic [1:0]        i_op,
    input  gsa_pkg::t_dp_stat i_stat,
    output gsa_pkg::t_dp_cmd  o_cmd,
    output logic              o_in_stall
);
    import gsa_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   accept;

    assign accept = (r_state == S_IDLE) && i_in_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_BOOT;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_BOOT: begin
                if (i_stat.grow_done) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    if (i_op == OP_ALLOC) begin
                        if (!i_stat.fc_zero) n_state = S_POP;
                        else if (i_stat.cap_max) n_state = S_FIN;
                        else n_state = S_GROW;
                    end else begin
                        n_state = S_FIN;
                    end
                end
            end
            S_GROW: begin
                if (i_stat.grow_done) n_state = S_ISSUE;
            end
            S_ISSUE: n_state = S_POP;
            S_POP:   n_state = S_FIN;
            S_FIN: begin
                if (i_stat.out_free) n_state = S_IDLE;
            end
            default: n_state = S_BOOT;
        endcase
    end

    always_comb begin
        o_cmd             = '0;
        o_cmd.accept      = accept;
        o_cmd.grow_start  = accept && (i_op == OP_ALLOC) && i_stat.fc_zero && !i_stat.cap_max;
        o_cmd.grow_step   = (r_state == S_BOOT) || (r_state == S_GROW);
        o_cmd.rd_stack    = (r_state == S_ISSUE) ||
                            (accept && (i_op == OP_ALLOC) && !i_stat.fc_zero);
        o_cmd.rd_gen_idx  = accept && ((i_op == OP_FREE) || (i_op == OP_CHECK));
        o_cmd.rd_gen_slot = (r_state == S_POP);
        o_cmd.finish      = (r_state == S_FIN) && i_stat.out_free;
        o_in_stall        = (r_state != S_IDLE);
    end

endmodule

// ----- sv/gsa_dp.sv -----
module gsa_dp #(
    parameter int MAX_SLOTS     = gsa_pkg::MAX_SLOTS_DEF,
    parameter int INITIAL_SLOTS = gsa_pkg::INITIAL_SLOTS_DEF,
    parameter int GEN_WIDTH     = gsa_pkg::GEN_WIDTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  gsa_pkg::t_dp_cmd   i_cmd,
    input  gsa_pkg::t_in_item  i_in_data,
    input  logic               i_out_stall,
    output gsa_pkg::t_dp_stat  o_stat,
    output logic               o_out_valid,
    output gsa_pkg::t_out_item o_out_data
);
    import gsa_pkg::*;

    localparam int IDX_W    = $clog2(MAX_SLOTS);
    localparam int CNT_W    = $clog2(MAX_SLOTS + 1);
    localparam int INIT_CAP = (INITIAL_SLOTS < MAX_SLOTS) ? INITIAL_SLOTS : MAX_SLOTS;

    logic [IDX_W-1:0]     stack_mem [MAX_SLOTS];
    logic [GEN_WIDTH-1:0] gen_mem   [MAX_SLOTS];

    logic [CNT_W-1:0]     r_cap, r_fc, r_gi, r_new_cap;
    logic [CNT_W-1:0]     n_fc;
    t_in_item             r_item;
    logic [IDX_W-1:0]     r_stack_q;
    logic [GEN_WIDTH-1:0] r_gen_q;
    t_out_item            r_out;
    logic                 r_out_valid;

    logic [CNT_W:0]       dbl_cap;
    logic [CNT_W-1:0]     grow_cap;
    logic                 grow_active;
    logic                 out_free;
    logic                 hv;
    t_out_item            res;

    logic                 stack_we;
    logic [IDX_W-1:0]     stack_waddr, stack_wdata, stack_raddr;
    logic                 gen_we, gen_re;
    logic [IDX_W-1:0]     gen_waddr, gen_raddr;
    logic [GEN_WIDTH-1:0] gen_wdata;
    logic                 push_ok;

    assign out_free    = !r_out_valid || !i_out_stall;
    assign grow_active = i_cmd.grow_step && (r_gi != r_cap);

    assign o_stat.fc_zero   = (r_fc == '0);
    assign o_stat.cap_max   = (r_cap == CNT_W'(MAX_SLOTS));
    assign o_stat.grow_done = (r_gi == r_cap);
    assign o_stat.out_free  = out_free;

    // Next capacity: double, at least the floor, at most the bound
    always_comb begin
        dbl_cap = {r_cap, 1'b0};
        if (dbl_cap < (CNT_W+1)'(GROW_FLOOR)) dbl_cap = (CNT_W+1)'(GROW_FLOOR);
        if (dbl_cap > (CNT_W+1)'(MAX_SLOTS))  dbl_cap = (CNT_W+1)'(MAX_SLOTS);
        grow_cap = CNT_W'(dbl_cap);
    end

    assign hv = !r_item.is_null && (32'(r_item.slot_index) < 32'(r_cap));

    always_comb begin
        res                   = '0;
        n_fc                  = r_fc;
        push_ok               = 1'b0;
        res.status            = STS_OK;
        case (r_item.operation)
            OP_ALLOC: begin
                if (r_fc != '0) begin
                    res.result_index      = 12'(r_stack_q);
                    res.result_generation = 16'(r_gen_q);
                    n_fc                  = r_fc - CNT_W'(1);
                end else begin
                    res.status = STS_FULL;
                end
            end
            OP_FREE: begin
                if (!hv) begin
                    res.status = STS_IGNORED;
                end else if (r_fc >= r_cap) begin
                    res.status = STS_OVERFLOW;
                end else begin
                    push_ok = 1'b1;
                    n_fc    = r_fc + CNT_W'(1);
                end
            end
            OP_CHECK: begin
                res.handle_ok = hv && (32'(r_gen_q) == 32'(r_item.handle_generation));
            end
            default: ;
        endcase
        res.allocated_count = 13'(r_cap - n_fc);
    end

    // Memory port selection
    always_comb begin
        stack_we    = 1'b0;
        stack_waddr = IDX_W'(r_fc);
        stack_wdata = IDX_W'(r_item.slot_index);
        gen_we      = 1'b0;
        gen_waddr   = IDX_W'(r_item.slot_index);
        gen_wdata   = GEN_WIDTH'(r_gen_q + 1'b1);
        if (grow_active) begin
            stack_we    = 1'b1;
            stack_wdata = IDX_W'(r_gi - CNT_W'(1));
            gen_we      = 1'b1;
            gen_waddr   = IDX_W'(r_gi - CNT_W'(1));
            gen_wdata   = GEN_WIDTH'(1);
        end else if (i_cmd.finish && (r_item.operation == OP_FREE) && hv) begin
            gen_we   = 1'b1;
            stack_we = push_ok;
        end
        stack_raddr = IDX_W'(r_fc - CNT_W'(1));
        gen_re      = i_cmd.rd_gen_idx || i_cmd.rd_gen_slot;
        gen_raddr   = i_cmd.rd_gen_slot ? r_stack_q : IDX_W'(i_in_data.slot_index);
    end

    always_ff @(posedge i_clk) begin
        if (stack_we) stack_mem[stack_waddr] <= stack_wdata;
        if (i_cmd.rd_stack) r_stack_q <= stack_mem[stack_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (gen_we) gen_mem[gen_waddr] <= gen_wdata;
        if (gen_re) r_gen_q <= gen_mem[gen_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) r_item <= i_in_data;
        if (i_cmd.finish) r_out <= res;
    end

    // Reset starts an empty table and grows it to the initial capacity
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap       <= '0;
            r_fc        <= '0;
            r_gi        <= CNT_W'(INIT_CAP);
            r_new_cap   <= CNT_W'(INIT_CAP);
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.grow_start) begin
                r_gi      <= grow_cap;
                r_new_cap <= grow_cap;
            end else if (grow_active) begin
                r_gi <= r_gi - CNT_W'(1);
                r_fc <= r_fc + CNT_W'(1);
            end else if (i_cmd.grow_step) begin
                r_cap <= r_new_cap;
            end else if (i_cmd.finish) begin
                r_fc <= n_fc;
            end
            if (i_cmd.finish) r_out_valid <= 1'b1;
            else if (!i_out_stall) r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    a_fc_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fc <= r_new_cap)
        else $error("free count beyond capacity");

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.rd_stack |-> (r_fc != '0))
        else $error("stack read while empty");

    a_grow_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        grow_active |=> (r_fc == $past(r_fc) + CNT_W'(1)))
        else $error("grow step did not push");

    a_out_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.finish |=> r_out_valid)
        else $error("finished transaction not presented");

endmodule

// ----- bench/testbench.sv -----
`timescale 1ns / 100ps

module testbench;
    import gsa_pkg::*;

    localparam int SLOTS     = MAX_SLOTS_DEF;
    localparam int FIRST_CAP = (INITIAL_SLOTS_DEF < MAX_SLOTS_DEF) ?
                               INITIAL_SLOTS_DEF : MAX_SLOTS_DEF;
    localparam int IDLE_MAX  = 18;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    typedef struct packed {
        logic [11:0] idx;
        logic [15:0] gen;
    } t_handle;

    // Mirror of the slot table; predicts one result per accepted transaction.
    class slot_ledger;
        logic [11:0] free_stack [SLOTS];
        logic [15:0] gen_table [SLOTS];
        int          free_count;
        int          capacity;
        t_out_item   pending_results [$];
        int          errors;

        function new();
            capacity   = FIRST_CAP;
            free_count = capacity;
            errors     = 0;
            for (int i = 0; i < SLOTS; i++) begin
                gen_table[i]  = 16'd1;
                free_stack[i] = (i < capacity) ? 12'(capacity - 1 - i) : 12'd0;
            end
        endfunction

        // Push the new slots highest first so the lowest pops first.
        function bit extend_table();
            int new_cap;
            if (capacity >= SLOTS) return 1'b0;
            new_cap = capacity * 2;
            if (new_cap < GROW_FLOOR) new_cap = GROW_FLOOR;
            if (new_cap > SLOTS) new_cap = SLOTS;
            for (int i = new_cap; i > capacity; i--) begin
                gen_table[i - 1] = 16'd1;
                if (free_count < SLOTS) begin
                    free_stack[free_count] = 12'(i - 1);
                    free_count++;
                end
            end
            capacity = new_cap;
            return 1'b1;
        endfunction

        function t_out_item allocator_step(t_in_item item);
            t_out_item   r;
            bit          have;
            logic [11:0] slot;
            r = '0;
            case (item.operation)
                OP_ALLOC: begin
                    have = 1'b1;
                    if (free_count == 0) have = extend_table();
                    if (have && free_count > 0) begin
                        free_count--;
                        slot = free_stack[free_count];
                        r.result_index      = slot;
                        r.result_generation = gen_table[slot];
                    end else begin
                        r.status = STS_FULL;
                    end
                end
                OP_FREE: begin
                    if (item.is_null || item.slot_index >= capacity) begin
                        r.status = STS_IGNORED;
                    end else begin
                        gen_table[item.slot_index] = gen_table[item.slot_index] + 16'd1;
                        if (free_count >= capacity || free_count >= SLOTS) begin
                            r.status = STS_OVERFLOW;
                        end else begin
                            free_stack[free_count] = item.slot_index;
                            free_count++;
                        end
                    end
                end
                OP_CHECK: begin
                    r.handle_ok = !item.is_null && item.slot_index < capacity &&
                                  gen_table[item.slot_index] == item.handle_generation;
                end
                default: ;
            endcase
            r.allocated_count = 13'(capacity - free_count);
            return r;
        endfunction

        function t_out_item note_request(t_in_item item);
            t_out_item r;
            r = allocator_step(item);
            pending_results.push_back(r);
            return r;
        endfunction

        function void mismatch(string field, logic [15:0] want, logic [15:0] got);
            $display("%0t: %s expected %0h, got %0h", $time, field, want, got);
            errors++;
        endfunction

        function void check_response(t_out_item got);
            t_out_item want;
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected transaction, expected none, got %h", $time, got);
                errors++;
                return;
            end
            want = pending_results.pop_front();
            if (got.result_index !== want.result_index)
                mismatch("result_index", 16'(want.result_index), 16'(got.result_index));
            if (got.result_generation !== want.result_generation)
                mismatch("result_generation", want.result_generation, got.result_generation);
            if (got.handle_ok !== want.handle_ok)
                mismatch("handle_ok", 16'(want.handle_ok), 16'(got.handle_ok));
            if (got.status !== want.status)
                mismatch("status", 16'(want.status), 16'(got.status));
            if (got.allocated_count !== want.allocated_count)
                mismatch("allocated_count", 16'(want.allocated_count),
                         16'(got.allocated_count));
        endfunction
    endclass

    logic      i_clk     = 1'b0;
    logic      i_rst_n   = 1'b0;
    logic      in_valid  = 1'b0;
    logic      out_stall = 1'b0;
    t_in_item  in_data   = '0;
    logic      in_stall;
    logic      out_valid;
    t_out_item out_data;

    t_out_item  last_pred;
    t_handle    live_handles [$];
    t_handle    stale_handles [$];
    slot_ledger ledger = new();

    generational_slot_allocator dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data)
    );

    always #5 i_clk = ~i_clk;

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_item(input t_in_item item);
        int      gap;
        t_handle h;
        gap = $urandom_range(0, IDLE_MAX);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        @(posedge i_clk);
        while (in_stall !== 1'b0) @(posedge i_clk);
        last_pred = ledger.note_request(item);
        if (item.operation == OP_ALLOC && last_pred.status == STS_OK) begin
            h.idx = last_pred.result_index;
            h.gen = last_pred.result_generation;
            live_handles.push_back(h);
        end
        @(negedge i_clk);
    endtask

    task automatic issue(input logic [1:0] op, input logic [11:0] idx,
                         input logic [15:0] gen, input logic nul);
        t_in_item item;
        item.operation         = op;
        item.slot_index        = idx;
        item.handle_generation = gen;
        item.is_null           = nul;
        send_item(item);
    endtask

    // Mostly well-formed use of held handles, with some stale and raw noise.
    function automatic t_in_item random_item();
        t_in_item item;
        t_handle  h;
        int       pick;
        int       k;
        item.operation         = OP_CHECK;
        item.slot_index        = 12'($urandom);
        item.handle_generation = 16'($urandom);
        item.is_null           = 1'b0;
        pick = $urandom_range(0, 99);
        if (pick < 35) begin
            item.operation = OP_ALLOC;
        end else if (pick < 65 && live_handles.size() > 0) begin
            k = $urandom_range(0, live_handles.size() - 1);
            h = live_handles[k];
            live_handles.delete(k);
            stale_handles.push_back(h);
            if (stale_handles.size() > 64) void'(stale_handles.pop_front());
            item.operation         = OP_FREE;
            item.slot_index        = h.idx;
            item.handle_generation = h.gen;
        end else if (pick < 80 && live_handles.size() > 0) begin
            h = live_handles[$urandom_range(0, live_handles.size() - 1)];
            item.slot_index        = h.idx;
            item.handle_generation = h.gen;
        end else if (pick < 87 && stale_handles.size() > 0) begin
            h = stale_handles[$urandom_range(0, stale_handles.size() - 1)];
            item.operation         = $urandom_range(0, 1) ? OP_FREE : OP_CHECK;
            item.slot_index        = h.idx;
            item.handle_generation = h.gen;
        end else if (pick < 92) begin
            item.operation = $urandom_range(0, 1) ? OP_FREE : OP_CHECK;
            item.is_null   = 1'b1;
        end else if (pick < 94) begin
            item.operation = OP_UNUSED;
            item.is_null   = 1'($urandom);
        end else begin
            item.operation = 2'($urandom);
            item.is_null   = 1'($urandom);
        end
        return item;
    endfunction

    task automatic run_random(input int count);
        for (int n = 0; n < count; n++)
            send_item(random_item());
    endtask

    // Result side: stall for a drawn number of cycles, then take one transaction.
    initial begin
        int n;
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);
        forever begin
            n = $urandom_range(0, IDLE_MAX);
            if (n > 0) begin
                out_stall <= 1'b1;
                repeat (n) @(negedge i_clk);
            end
            out_stall <= 1'b0;
            @(posedge i_clk);
            while (out_valid !== 1'b1) @(posedge i_clk);
            ledger.check_response(out_data);
            @(negedge i_clk);
        end
    end

    initial begin
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;

        issue(OP_CHECK, 12'd0, 16'd1, 1'b0);
        issue(OP_CHECK, 12'd0, 16'hFFFF, 1'b0);
        issue(OP_CHECK, 12'd0, 16'd1, 1'b1);
        issue(OP_CHECK, 12'(FIRST_CAP), 16'd1, 1'b0);
        issue(OP_CHECK, 12'hFFF, 16'd0, 1'b0);
        issue(OP_FREE, 12'd0, 16'd1, 1'b1);
        issue(OP_FREE, 12'(FIRST_CAP), 16'd1, 1'b0);
        issue(OP_FREE, 12'hFFF, 16'hFFFF, 1'b0);
        // double free while every slot is already on the stack
        issue(OP_FREE, 12'(FIRST_CAP - 1), 16'd1, 1'b0);
        issue(OP_CHECK, 12'(FIRST_CAP - 1), 16'd2, 1'b0);
        issue(OP_UNUSED, 12'hFFF, 16'hFFFF, 1'b1);
        issue(OP_UNUSED, 12'd0, 16'd0, 1'b0);
        issue(OP_ALLOC, 12'hFFF, 16'hFFFF, 1'b1);
        issue(OP_CHECK, 12'd0, 16'd1, 1'b0);
        issue(OP_FREE, 12'd0, 16'd1, 1'b0);
        issue(OP_FREE, 12'd0, 16'd2, 1'b0);
        issue(OP_ALLOC, 12'd0, 16'd0, 1'b0);

        run_random(200);

        // Allocate in a burst so the free stack runs dry and the table grows.
        for (int n = 0; n < 80; n++)
            issue(OP_ALLOC, 12'($urandom), 16'($urandom), 1'($urandom));

        run_random(150);
        in_valid <= 1'b0;

        for (int c = 0; c < 2000 && ledger.pending_results.size() > 0; c++)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (ledger.pending_results.size() > 0)
            $display("%0t: %0d results never arrived", $time,
                     ledger.pending_results.size());
        if (ledger.errors == 0 && ledger.pending_results.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("%0t: timeout", $time);
        $display("end of test: mismatches");
        $finish;
    end

endmodule
